@@ rtl/core/ihex_pkg.sv @@
// ----------------------------------------------------------------------------
// ihex_pkg
// Types and constants shared by the HEX record loader.
// ----------------------------------------------------------------------------
package ihex_pkg;

  localparam logic [1:0] KIND_CHAR    = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [1:0] KIND_READ    = 2'd2;

  localparam logic [2:0] ST_DATA    = 3'd0;
  localparam logic [2:0] ST_END     = 3'd1;
  localparam logic [2:0] ST_OTHER   = 3'd2;
  localparam logic [2:0] ST_SUMERR  = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;
  localparam logic [2:0] ST_READ    = 3'd5;

  localparam logic [7:0]  CHAR_COLON = 8'h3a;
  localparam logic [7:0]  TYPE_DATA  = 8'h00;
  localparam logic [7:0]  TYPE_EOF   = 8'h01;
  localparam logic [23:0] TOTAL_MAX  = 24'hffffff;
  localparam logic [16:0] COVER_LOW_RST = 17'h10000;

  typedef enum logic [3:0] {
    PH_HUNT = 4'd0, PH_LEN = 4'd1, PH_AHI = 4'd2, PH_ALO = 4'd3,
    PH_TYPE = 4'd4, PH_DATA = 4'd5, PH_SUM = 4'd6, PH_DRAIN = 4'd7
  } phase_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_STEP  = 6'b000010,
    S_COPY  = 6'b000100,
    S_RDW   = 6'b001000,
    S_RDATA = 6'b010000,
    S_FIN   = 6'b100000
  } seq_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  rx_char;
    logic [15:0] read_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  record_type;
    logic [15:0] record_address;
    logic [7:0]  bytes_stored;
    logic [23:0] total_stored;
    logic [16:0] range_begin;
    logic [16:0] range_end;
    logic [7:0]  bad_sum;
    logic [7:0]  read_byte;
  } out_item_t;

  function automatic logic [3:0] hex_value(input logic [7:0] ch);
    logic [3:0] v;
    v = 4'd0;
    if (ch >= 8'h30 && ch <= 8'h39) v = ch[3:0];
    else if ((ch >= 8'h41 && ch <= 8'h46) || (ch >= 8'h61 && ch <= 8'h66))
      v = ch[3:0] + 4'd9;
    return v;
  endfunction

endpackage

@@ rtl/core/ihex_ram.sv @@
// ----------------------------------------------------------------------------
// ihex_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ihex_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/core/intel_hex_record_loader.sv @@
// ----------------------------------------------------------------------------
// intel_hex_record_loader
// Parses Intel HEX records from a character stream into an image memory and serves byte reads from it.
// ----------------------------------------------------------------------------
// Committing a good data record copies its payload from the line buffer to
// image memory one byte a cycle through a single address counter. The block
// is not ready while an item is being worked on or while a result waits to
// be taken.
module intel_hex_record_loader #(
  parameter int IMAGE_ADDR_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  ihex_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output ihex_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [16:0]         cfg_wdata
);
  localparam logic [16:0] IMG_SIZE = 17'(1 << IMAGE_ADDR_BITS);

  ihex_pkg::seq_t      seq_r, seq_nxt;
  ihex_pkg::phase_t    phase_r, phase_nxt;
  ihex_pkg::in_item_t  item_r;
  ihex_pkg::out_item_t res_r, res_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [16:0] mem_end_r;
  logic        nib_r, nib_nxt;
  logic [3:0]  hi_r, hi_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [23:0] total_r, total_nxt;
  logic [16:0] low_r, low_nxt;
  logic [16:0] high_r, high_nxt;
  logic [7:0]  ncopy_r, ncopy_nxt;
  logic [7:0]  idx_r, idx_nxt;

  logic        lb_we;
  logic [7:0]  lb_rdata;
  logic        img_we;
  logic [IMAGE_ADDR_BITS-1:0] img_waddr, img_raddr;
  logic [7:0]  img_rdata;
  logic [7:0]  byte_val, sum_add;
  logic [16:0] lim, room, top;
  logic [24:0] tsum;
  logic        copy_we_r;
  logic [IMAGE_ADDR_BITS-1:0] copy_addr_r;

  ihex_ram #(.WIDTH(8), .DEPTH(256)) u_line (
    .clk(clk), .we(lb_we), .waddr(cnt_r), .wdata(byte_val),
    .raddr(idx_r), .rdata(lb_rdata)
  );

  ihex_ram #(.WIDTH(8), .DEPTH(1 << IMAGE_ADDR_BITS)) u_image (
    .clk(clk), .we(img_we), .waddr(img_waddr), .wdata(lb_rdata),
    .raddr(img_raddr), .rdata(img_rdata)
  );

  assign in_ready  = (seq_r == ihex_pkg::S_IDLE) && !out_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = res_r;
  assign byte_val  = {hi_r, ihex_pkg::hex_value(item_r.rx_char)};
  assign sum_add   = sum_r + byte_val;
  assign img_we    = copy_we_r;
  assign img_waddr = copy_addr_r;
  assign img_raddr = item_r.read_address[IMAGE_ADDR_BITS-1:0];
  assign lim  = (mem_end_r < IMG_SIZE) ? mem_end_r : IMG_SIZE;
  assign room = lim - {1'b0, addr_r};
  assign top  = {1'b0, addr_r} + {9'd0, ncopy_r};
  assign tsum = {1'b0, total_r} + {17'd0, ncopy_r};
  assign lb_we = (seq_r == ihex_pkg::S_STEP) && (phase_r == ihex_pkg::PH_DATA)
                 && (item_r.kind == ihex_pkg::KIND_CHAR) && nib_r;

  always_comb begin
    seq_nxt = seq_r; phase_nxt = phase_r; res_nxt = res_r;
    out_valid_nxt = out_valid_r; nib_nxt = nib_r; hi_nxt = hi_r;
    len_nxt = len_r; addr_nxt = addr_r; type_nxt = type_r; cnt_nxt = cnt_r;
    sum_nxt = sum_r; total_nxt = total_r; low_nxt = low_r; high_nxt = high_r;
    ncopy_nxt = ncopy_r; idx_nxt = idx_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    case (seq_r)
      ihex_pkg::S_IDLE: begin
        if (in_valid && in_ready) seq_nxt = ihex_pkg::S_STEP;
      end
      ihex_pkg::S_STEP: begin
        seq_nxt = ihex_pkg::S_IDLE;
        res_nxt = '0;
        res_nxt.total_stored = total_r;
        res_nxt.range_begin  = low_r;
        res_nxt.range_end    = high_r;
        res_nxt.record_type  = type_r;
        res_nxt.record_address = addr_r;
        case (item_r.kind)
          ihex_pkg::KIND_READ: seq_nxt = ihex_pkg::S_RDW;
          ihex_pkg::KIND_TIMEOUT: begin
            if (phase_r != ihex_pkg::PH_DRAIN) begin
              res_nxt.status = ihex_pkg::ST_TIMEOUT;
              res_nxt.record_type = '0;
              res_nxt.record_address = '0;
              out_valid_nxt = 1'b1;
            end
            total_nxt = '0; low_nxt = ihex_pkg::COVER_LOW_RST; high_nxt = '0;
            phase_nxt = ihex_pkg::PH_HUNT; nib_nxt = 1'b0;
          end
          ihex_pkg::KIND_CHAR: begin
            if (phase_r == ihex_pkg::PH_HUNT) begin
              if (item_r.rx_char == ihex_pkg::CHAR_COLON) begin
                phase_nxt = ihex_pkg::PH_LEN; nib_nxt = 1'b0;
              end
            end else if (phase_r == ihex_pkg::PH_DRAIN) begin
              phase_nxt = phase_r;
            end else if (!nib_r) begin
              hi_nxt = ihex_pkg::hex_value(item_r.rx_char);
              nib_nxt = 1'b1;
            end else begin
              nib_nxt = 1'b0;
              case (phase_r)
                ihex_pkg::PH_LEN: begin
                  len_nxt = byte_val; sum_nxt = byte_val;
                  phase_nxt = ihex_pkg::PH_AHI;
                end
                ihex_pkg::PH_AHI: begin
                  addr_nxt = {byte_val, 8'd0}; sum_nxt = sum_add;
                  phase_nxt = ihex_pkg::PH_ALO;
                end
                ihex_pkg::PH_ALO: begin
                  addr_nxt = {addr_r[15:8], byte_val}; sum_nxt = sum_add;
                  phase_nxt = ihex_pkg::PH_TYPE;
                end
                ihex_pkg::PH_TYPE: begin
                  type_nxt = byte_val; sum_nxt = sum_add; cnt_nxt = '0;
                  phase_nxt = (len_r == 8'd0) ? ihex_pkg::PH_SUM : ihex_pkg::PH_DATA;
                end
                ihex_pkg::PH_DATA: begin
                  sum_nxt = sum_add; cnt_nxt = cnt_r + 8'd1;
                  if (cnt_r + 8'd1 == len_r) phase_nxt = ihex_pkg::PH_SUM;
                end
                ihex_pkg::PH_SUM: begin
                  sum_nxt = sum_add;
                  phase_nxt = ihex_pkg::PH_HUNT;
                  if (sum_add != 8'd0) begin
                    res_nxt.status = ihex_pkg::ST_SUMERR;
                    res_nxt.bad_sum = sum_add;
                    out_valid_nxt = 1'b1;
                    total_nxt = '0; low_nxt = ihex_pkg::COVER_LOW_RST; high_nxt = '0;
                  end else if (type_r == ihex_pkg::TYPE_DATA) begin
                    if ({1'b0, addr_r} < lim)
                      ncopy_nxt = (room > {9'd0, len_r}) ? len_r : room[7:0];
                    else
                      ncopy_nxt = '0;
                    idx_nxt = '0;
                    seq_nxt = ihex_pkg::S_COPY;
                  end else if (type_r == ihex_pkg::TYPE_EOF) begin
                    res_nxt.status = ihex_pkg::ST_END;
                    out_valid_nxt = 1'b1;
                    phase_nxt = ihex_pkg::PH_DRAIN;
                  end else begin
                    res_nxt.status = ihex_pkg::ST_OTHER;
                    out_valid_nxt = 1'b1;
                  end
                end
                default: phase_nxt = ihex_pkg::PH_HUNT;
              endcase
            end
          end
          default: seq_nxt = ihex_pkg::S_IDLE;
        endcase
      end
      ihex_pkg::S_COPY: begin
        if (idx_r == ncopy_r) seq_nxt = ihex_pkg::S_FIN;
        else idx_nxt = idx_r + 8'd1;
      end
      ihex_pkg::S_FIN: begin
        if (ncopy_r != 8'd0) begin
          total_nxt = tsum[24] ? ihex_pkg::TOTAL_MAX : tsum[23:0];
          if (low_r > {1'b0, addr_r}) low_nxt = {1'b0, addr_r};
          if (high_r < top) high_nxt = top;
        end
        res_nxt.status = ihex_pkg::ST_DATA;
        res_nxt.bytes_stored = ncopy_r;
        res_nxt.total_stored = total_nxt;
        res_nxt.range_begin = low_nxt;
        res_nxt.range_end = high_nxt;
        out_valid_nxt = 1'b1;
        seq_nxt = ihex_pkg::S_IDLE;
      end
      ihex_pkg::S_RDW: seq_nxt = ihex_pkg::S_RDATA;
      ihex_pkg::S_RDATA: begin
        res_nxt = '0;
        res_nxt.status = ihex_pkg::ST_READ;
        res_nxt.read_byte = img_rdata;
        out_valid_nxt = 1'b1;
        seq_nxt = ihex_pkg::S_IDLE;
      end
      default: seq_nxt = ihex_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= ihex_pkg::S_IDLE;
      phase_r <= ihex_pkg::PH_HUNT;
      out_valid_r <= 1'b0;
      mem_end_r <= 17'h10000;
      nib_r <= 1'b0; hi_r <= '0; len_r <= '0; addr_r <= '0; type_r <= '0;
      cnt_r <= '0; sum_r <= '0; total_r <= '0;
      low_r <= ihex_pkg::COVER_LOW_RST; high_r <= '0;
      ncopy_r <= '0; idx_r <= '0; copy_we_r <= 1'b0;
    end else begin
      seq_r <= seq_nxt; phase_r <= phase_nxt; out_valid_r <= out_valid_nxt;
      if (cfg_we) mem_end_r <= cfg_wdata;
      nib_r <= nib_nxt; hi_r <= hi_nxt; len_r <= len_nxt; addr_r <= addr_nxt;
      type_r <= type_nxt; cnt_r <= cnt_nxt; sum_r <= sum_nxt;
      total_r <= total_nxt; low_r <= low_nxt; high_r <= high_nxt;
      ncopy_r <= ncopy_nxt; idx_r <= idx_nxt;
      copy_we_r <= (seq_r == ihex_pkg::S_COPY) && (idx_r != ncopy_r);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    copy_addr_r <= addr_r[IMAGE_ADDR_BITS-1:0] + IMAGE_ADDR_BITS'(idx_r);
    if (in_valid && in_ready) item_r <= in_data;
  end

`ifndef NO_ASSERTIONS
  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r != ihex_pkg::S_IDLE) |-> !in_ready) else $error("ready while busy");
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(res_r)) else $error("result changed");
  a_copy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (seq_r == ihex_pkg::S_COPY) |-> (idx_r <= ncopy_r)) else $error("copy overrun");
  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    (total_r != '0) |-> (low_r < high_r)) else $error("bad range");
`endif
endmodule
